// File: rtl/fmop_pkg.sv
// Package for the FM sine operator engine: states, constants and helpers.
package fmop_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int CHANNELS_DEF = 2;

  localparam logic [16:0] PHASE_WRAP = 17'd96000;
  localparam logic [16:0] PHASE_MAX  = 17'd95999;
  localparam logic [16:0] QUARTER    = 17'd24000;
  localparam logic [16:0] HALF_WAVE  = 17'd48000;
  localparam logic [16:0] THREE_QTR  = 17'd72000;
  localparam logic [28:0] INC_NUM    = 29'd196608000;
  localparam logic [30:0] Z_ROUND    = 31'd12000;
  localparam logic [12:0] POLY_C     = 13'd4640;
  localparam logic [15:0] POLY_B     = 16'd42047;
  localparam logic [16:0] POLY_A     = 17'd102944;
  localparam logic [12:0] SINE_CAP   = 13'd4096;
  localparam logic [4:0]  DIV_STEPS  = 5'd30;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISP,
    ST_MUL,
    ST_DIVSET,
    ST_PDIV,
    ST_PINC,
    ST_ADV,
    ST_SREG,
    ST_ZDIV,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_PROD,
    ST_ACC,
    ST_LAST,
    ST_SWEEP
  } fmop_state_t;

  // Saturating 24-bit accumulate of a 19-bit contribution.
  function automatic logic signed [23:0] sat_acc(logic signed [23:0] acc,
                                                 logic signed [18:0] c);
    logic signed [24:0] s;
    s = {acc[23], acc} + {{6{c[18]}}, c};
    if (s > 25'sd8388607) return 24'sd8388607;
    if (s < -25'sd8388608) return -24'sd8388608;
    return s[23:0];
  endfunction

endpackage

// File: rtl/fm_operator_sine_synth.sv
// Top level of the FM sine operator engine.
//
// Items arrive on the in_ channel (valid/ready) one operator slot at a time,
// for one channel; the sender must give slots from highest to lowest, as the
// block does not enforce this order. A load item sets a slot's phase; an
// evaluate item advances the phase and adds its sine contribution into a
// modulation accumulator or the channel output. The last evaluate item of a
// sample places the saturated channel sum on the out_ channel. The block
// works on one transaction at a time and keeps the input closed until an
// item is done. An evaluate item runs two 31-step bit-serial restoring
// divisions (the phase increment, then the sine argument scaling) besides
// multiply steps and memory access. A scaled wavelength
// that is not positive or not below INC_NUM skips the first division,
// and a modulator with an absent target skips the sine, so those items finish
// sooner. A load returns to idle right after dispatch. The last item of a
// sample then sweeps the slots to clear that channel's accumulators.
// After reset the phase and modulation memories are cleared, one entry a
// cycle over all SLOTS*CHANNELS entries, while in_ready stays low. A result waits
// in the output register while the receiver stalls; the next items are still
// accepted, and only a further last item waits for the register to drain.
module fm_operator_sine_synth
  import fmop_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [3:0]         in_slot,
  input  logic               in_channel,
  input  logic signed [15:0] in_amplitude,
  input  logic [15:0]        in_wavelength,
  input  logic [4:0]         in_target,
  input  logic [16:0]        in_start_phase,
  input  logic               in_last_of_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_sample_out,
  output logic               out_out_channel
);

  localparam int N  = SLOTS * CHANNELS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  fmop_state_t state_r, state_nxt;

  // Latched transaction fields.
  logic               kind_r, ch_r, last_r;
  logic [3:0]         slot_r;
  logic signed [15:0] amp_r;
  logic [15:0]        wvl_r;
  logic [4:0]         tgt_r;
  logic [16:0]        start_r;

  // Memories with registered reads.
  logic [16:0]        ph_mem [N];
  logic signed [23:0] mod_mem [N];
  logic [16:0]        ph_rd_r;
  logic signed [23:0] mod_rd_r;
  logic               ph_we, mod_we, rd_en;
  logic [IW-1:0]      ph_wa, mod_wa, mod_ra;
  logic [16:0]        ph_wd;
  logic signed [23:0] mod_wd;

  logic signed [23:0] osum_r [CHANNELS];

  // Datapath registers.
  logic [16:0]        old_r, inc_r, p_r;
  logic               neg_r, carrier_r;
  logic signed [41:0] wl_r;
  logic [29:0]        rem_r;
  logic [30:0]        dvd_r;
  logic [28:0]        dvs_r;
  logic [4:0]         dcnt_r;
  logic [33:0]        mul_r;
  logic [16:0]        z_r, z2_r;
  logic signed [29:0] sp_r;
  logic [IW-1:0]      clr_r;
  logic [SW-1:0]      sw_r;

  logic               out_valid_r, out_ch_r;
  logic signed [23:0] out_data_r;

  // Address and range decode.
  logic          ch_ok, slot_ok, tgt_ok, out_free;
  logic [IW-1:0] idx, tidx, sidx;
  logic [CW-1:0] chi;

  assign ch_ok    = 32'(ch_r) < CHANNELS;
  assign slot_ok  = 32'(slot_r) < SLOTS;
  assign tgt_ok   = (tgt_r != 5'd0) && (32'(tgt_r) <= SLOTS);
  assign idx      = IW'(32'(slot_r) * CHANNELS + 32'(ch_r));
  assign tidx     = IW'((32'(tgt_r) - 1) * CHANNELS + 32'(ch_r));
  assign sidx     = IW'(32'(sw_r) * CHANNELS + 32'(ch_r));
  assign chi      = CW'(ch_r);
  assign out_free = !out_valid_r || out_ready;

  // Divider step, shared by both divisions.
  logic [29:0] trial;
  logic        qbit;
  assign trial = {rem_r[28:0], dvd_r[30]};
  assign qbit  = trial >= {1'b0, dvs_r};

  // Phase advance.
  logic [17:0] sum_ph;
  logic [16:0] nxt_ph;
  assign sum_ph = {1'b0, old_r} + {1'b0, inc_r};
  assign nxt_ph = (sum_ph >= {1'b0, PHASE_WRAP}) ? 17'(sum_ph - {1'b0, PHASE_WRAP})
                                                 : sum_ph[16:0];

  // Quarter-wave folding.
  logic [1:0]  quad;
  logic [16:0] qbase, rr;
  logic [14:0] xx;
  always_comb begin
    if (p_r < QUARTER) begin
      quad = 2'd0; qbase = 17'd0;
    end else if (p_r < HALF_WAVE) begin
      quad = 2'd1; qbase = QUARTER;
    end else if (p_r < THREE_QTR) begin
      quad = 2'd2; qbase = HALF_WAVE;
    end else begin
      quad = 2'd3; qbase = THREE_QTR;
    end
    rr = p_r - qbase;
    xx = quad[0] ? 15'(QUARTER - rr) : rr[14:0];
  end

  // Sine finish: round to Q.12, cap and apply sign.
  logic [17:0]        yv;
  logic [13:0]        yr;
  logic signed [13:0] sv;
  always_comb begin
    yv = mul_r[33:16];
    yr = 14'((yv + 18'd8) >> 4);
    if (yr > {1'b0, SINE_CAP}) yr = {1'b0, SINE_CAP};
    sv = neg_r ? -$signed(yr) : $signed(yr);
  end

  // Rounded product contribution.
  logic signed [30:0] sp_rnd;
  logic signed [18:0] contrib;
  assign sp_rnd  = {sp_r[29], sp_r} + 31'sd2048;
  assign contrib = sp_rnd[30:12];

  logic [16:0] t_p3, t_p4;
  assign t_p3 = 17'(POLY_B) - {1'b0, mul_r[31:16]};
  assign t_p4 = POLY_A - mul_r[32:16];

  // Next state and memory controls.
  always_comb begin
    state_nxt = state_r;
    ph_we  = 1'b0;
    ph_wa  = idx;
    ph_wd  = nxt_ph;
    mod_we = 1'b0;
    mod_wa = tidx;
    mod_wd = sat_acc(mod_rd_r, contrib);
    mod_ra = idx;
    rd_en  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ph_we = 1'b1; ph_wa = clr_r; ph_wd = '0;
        mod_we = 1'b1; mod_wa = clr_r; mod_wd = '0;
        if (32'(clr_r) == N - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (!ch_ok) begin
          state_nxt = ST_IDLE;
        end else if (kind_r) begin
          ph_we = slot_ok;
          ph_wd = (start_r >= PHASE_WRAP) ? start_r - PHASE_WRAP : start_r;
          state_nxt = ST_IDLE;
        end else if (slot_ok) begin
          rd_en = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_LAST;
        end
      end
      ST_MUL:    state_nxt = ST_DIVSET;
      ST_DIVSET: begin
        if (wl_r <= 42'sd0 || wl_r >= $signed({13'd0, INC_NUM})) state_nxt = ST_ADV;
        else state_nxt = ST_PDIV;
      end
      ST_PDIV:   if (dcnt_r == 5'd0) state_nxt = ST_PINC;
      ST_PINC:   state_nxt = ST_ADV;
      ST_ADV: begin
        ph_we = 1'b1;
        if (tgt_r == 5'd0 || tgt_ok) state_nxt = ST_SREG;
        else state_nxt = ST_LAST;
      end
      ST_SREG:   state_nxt = ST_ZDIV;
      ST_ZDIV:   if (dcnt_r == 5'd0) state_nxt = ST_P1;
      ST_P1:     state_nxt = ST_P2;
      ST_P2:     state_nxt = ST_P3;
      ST_P3:     state_nxt = ST_P4;
      ST_P4:     state_nxt = ST_PROD;
      ST_PROD: begin
        rd_en = 1'b1;
        mod_ra = tidx;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        mod_we = !carrier_r;
        state_nxt = ST_LAST;
      end
      ST_LAST: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (out_free) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        mod_we = 1'b1; mod_wa = sidx; mod_wd = '0;
        if (32'(sw_r) == SLOTS - 1) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    if (rd_en) ph_rd_r <= ph_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (mod_we) mod_mem[mod_wa] <= mod_wd;
    if (rd_en) mod_rd_r <= mod_mem[mod_ra];
  end

  // Control counters, accumulators and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      sw_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) osum_r[i] <= '0;
    end else begin
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_SWEEP) sw_r <= sw_r + 1'b1;
      else sw_r <= '0;
      if (state_r == ST_ACC && carrier_r) osum_r[chi] <= sat_acc(osum_r[chi], contrib);
      if (state_r == ST_LAST && last_r && out_free) begin
        out_valid_r <= 1'b1;
        osum_r[chi] <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        kind_r <= in_kind; slot_r <= in_slot; ch_r <= in_channel;
        amp_r <= in_amplitude; wvl_r <= in_wavelength; tgt_r <= in_target;
        start_r <= in_start_phase; last_r <= in_last_of_sample;
      end
      ST_MUL: begin
        old_r <= ph_rd_r;
        wl_r <= 42'($signed({1'b0, wvl_r}) * ($signed({mod_rd_r[23], mod_rd_r}) + 25'sd4096));
      end
      ST_DIVSET: begin
        if (wl_r <= 42'sd0) inc_r <= 17'd0;
        else inc_r <= 17'd1;
        rem_r <= '0;
        dvd_r <= {2'b00, 29'(INC_NUM + wl_r[28:0] - 29'd1)};
        dvs_r <= wl_r[28:0];
        dcnt_r <= DIV_STEPS;
      end
      ST_PDIV, ST_ZDIV: begin
        rem_r <= qbit ? trial - {1'b0, dvs_r} : trial;
        dvd_r <= {dvd_r[29:0], qbit};
        dcnt_r <= dcnt_r - 5'd1;
      end
      ST_PINC: inc_r <= (dvd_r > {14'd0, PHASE_MAX}) ? PHASE_MAX : dvd_r[16:0];
      ST_ADV: begin
        carrier_r <= (tgt_r == 5'd0);
        p_r <= (tgt_r == 5'd0) ? nxt_ph : old_r;
      end
      ST_SREG: begin
        neg_r <= quad[1];
        rem_r <= '0;
        dvd_r <= {xx, 16'd0} + Z_ROUND;
        dvs_r <= {12'd0, QUARTER};
        dcnt_r <= DIV_STEPS;
      end
      ST_P1: begin
        z_r <= dvd_r[16:0];
        mul_r <= 34'(dvd_r[16:0] * dvd_r[16:0]);
      end
      ST_P2: begin
        z2_r <= mul_r[32:16];
        mul_r <= 34'(POLY_C * mul_r[32:16]);
      end
      ST_P3: mul_r <= 34'(t_p3 * z2_r);
      ST_P4: mul_r <= 34'(t_p4 * z_r);
      ST_PROD: sp_r <= 30'(amp_r * sv);
      ST_LAST: if (last_r && out_free) begin
        out_data_r <= osum_r[chi];
        out_ch_r <= ch_r;
      end
      default: ;
    endcase
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_data_r;
  assign out_out_channel = out_ch_r;

endmodule

// File: rtl/fmop_checker.sv
// Port-level assertions for the FM sine operator engine, bound to the top level.
module fmop_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_sample_out,
  input logic        out_out_channel
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) &&
    $stable(out_out_channel))
    else $error("result changed while stalled");

  // The memory clearing pass keeps the input closed right after reset.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // One transaction at a time: the input closes after each acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  // A new result is produced only while an item is being worked on.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

endmodule

bind fm_operator_sine_synth fmop_checker u_fmop_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_sample_out(out_sample_out),
  .out_out_channel(out_out_channel)
);
